// File: src/acc_pkg.sv
// Shared types and constants for the accumulator CPU core.
package acc_pkg;

    localparam logic [31:0] SP_RESET      = 32'd1000;
    localparam logic [31:0] SP_KERNEL     = 32'd1999;
    localparam logic [31:0] VEC_TIMER     = 32'd1000;
    localparam logic [31:0] VEC_SYSCALL   = 32'd1500;
    localparam logic [15:0] LFSR_RESET    = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS     = 16'hB400;

    localparam logic [31:0] OPC_LOAD_IMM  = 32'd1;
    localparam logic [31:0] OPC_LOAD_DIR  = 32'd2;
    localparam logic [31:0] OPC_LOAD_IND  = 32'd3;
    localparam logic [31:0] OPC_LOAD_X    = 32'd4;
    localparam logic [31:0] OPC_LOAD_Y    = 32'd5;
    localparam logic [31:0] OPC_LOAD_SPX  = 32'd6;
    localparam logic [31:0] OPC_STORE     = 32'd7;
    localparam logic [31:0] OPC_RAND      = 32'd8;
    localparam logic [31:0] OPC_PUT       = 32'd9;
    localparam logic [31:0] OPC_ADD_X     = 32'd10;
    localparam logic [31:0] OPC_ADD_Y     = 32'd11;
    localparam logic [31:0] OPC_SUB_X     = 32'd12;
    localparam logic [31:0] OPC_SUB_Y     = 32'd13;
    localparam logic [31:0] OPC_CP_TO_X   = 32'd14;
    localparam logic [31:0] OPC_CP_FROM_X = 32'd15;
    localparam logic [31:0] OPC_CP_TO_Y   = 32'd16;
    localparam logic [31:0] OPC_CP_FROM_Y = 32'd17;
    localparam logic [31:0] OPC_CP_TO_SP  = 32'd18;
    localparam logic [31:0] OPC_CP_FROM_SP= 32'd19;
    localparam logic [31:0] OPC_JUMP      = 32'd20;
    localparam logic [31:0] OPC_JUMP_EQ   = 32'd21;
    localparam logic [31:0] OPC_JUMP_NE   = 32'd22;
    localparam logic [31:0] OPC_CALL      = 32'd23;
    localparam logic [31:0] OPC_RET       = 32'd24;
    localparam logic [31:0] OPC_INC_X     = 32'd25;
    localparam logic [31:0] OPC_DEC_X     = 32'd26;
    localparam logic [31:0] OPC_PUSH      = 32'd27;
    localparam logic [31:0] OPC_POP       = 32'd28;
    localparam logic [31:0] OPC_SYSCALL   = 32'd29;
    localparam logic [31:0] OPC_IRET      = 32'd30;
    localparam logic [31:0] OPC_END       = 32'd50;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_VIOL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_INT  = 2'd1;
    localparam logic [1:0] PK_CHAR = 2'd2;

    // One queued item between front and back.
    typedef struct packed {
        logic        op;
        logic [10:0] load_address;
        logic [31:0] load_value;
        logic        timer_irq;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  print_kind;
        logic [31:0] print_value;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_FETCH_W,
        S_ARG,
        S_ARG_W,
        S_EXEC,
        S_MEM_W,
        S_IND_W,
        S_POP_CLR,
        S_DONE
    } t_state;

    function automatic logic has_operand(input logic [31:0] opc);
        return (opc >= OPC_LOAD_IMM && opc <= OPC_LOAD_Y) || opc == OPC_STORE ||
               opc == OPC_PUT || (opc >= OPC_JUMP && opc <= OPC_CALL);
    endfunction

endpackage

// File: src/acc_ram.sv
// Generic single-port RAM with registered read.
module acc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/acc_front.sv
// Input stage: accepts items and holds them in a two-entry queue.
module acc_front
    import acc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_q_valid,
    input  logic  i_q_ready,
    output t_item o_q_item
);
    t_item      r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_slot[r_rptr];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_slot[r_wptr] <= i_item;
    end
endmodule

// File: src/acc_back.sv
// Execution sequencer: runs load and step items against the word memory.
module acc_back
    import acc_pkg::*;
#(
    parameter int MEM_DEPTH  = 2048,
    parameter int USER_LIMIT = 999
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    output logic    o_q_ready,
    input  t_item   i_q_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    localparam int AW = $clog2(MEM_DEPTH);

    t_state      r_state, n_state;
    logic [31:0] r_pc, n_pc, r_sp, n_sp, r_ssp, n_ssp, r_spc, n_spc;
    logic [31:0] r_ac, n_ac, r_x, n_x, r_y, n_y;
    logic [31:0] r_opc, n_opc, r_arg, n_arg;
    logic        r_kern, n_kern, r_stop, n_stop;
    logic [15:0] r_lfsr, n_lfsr;
    logic        r_ind, n_ind;
    logic        r_ovalid, n_ovalid;
    t_result     r_res, n_res;

    logic          we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   wdata, rdata;
    logic [31:0]   acc_a;
    logic          acc_go;
    logic [15:0]   lf;
    logic [6:0]    rnd;

    acc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (ram_addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    function automatic logic addr_ok(input logic [31:0] a, input logic kern);
        return (a < 32'(MEM_DEPTH)) && (kern || a <= 32'(USER_LIMIT));
    endfunction

    // lfsr mod 100: reciprocal estimate of the quotient (low by at most one),
    // then one correcting subtract
    function automatic logic [6:0] mod100(input logic [15:0] v);
        logic [25:0] prod;
        logic [16:0] rem;
        prod = 26'(v) * 26'd655;
        rem  = {1'b0, v} - 17'(prod[25:16]) * 17'd100;
        if (rem >= 17'd100) rem = rem - 17'd100;
        return rem[6:0];
    endfunction

    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign ram_addr = acc_a[AW-1:0];
    assign lf  = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0);
    assign rnd = mod100(lf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_sp     <= SP_RESET;
            r_ssp    <= '0;
            r_spc    <= '0;
            r_ac     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_kern   <= 1'b0;
            r_stop   <= 1'b0;
            r_lfsr   <= LFSR_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_sp     <= n_sp;
            r_ssp    <= n_ssp;
            r_spc    <= n_spc;
            r_ac     <= n_ac;
            r_x      <= n_x;
            r_y      <= n_y;
            r_kern   <= n_kern;
            r_stop   <= n_stop;
            r_lfsr   <= n_lfsr;
            r_ovalid <= n_ovalid;
        end
        r_opc <= n_opc;
        r_arg <= n_arg;
        r_ind <= n_ind;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state; n_pc = r_pc; n_sp = r_sp; n_ssp = r_ssp; n_spc = r_spc;
        n_ac = r_ac; n_x = r_x; n_y = r_y; n_kern = r_kern; n_stop = r_stop;
        n_lfsr = r_lfsr; n_opc = r_opc; n_arg = r_arg; n_ind = r_ind;
        n_res = r_res; n_ovalid = r_ovalid;
        o_q_ready = 1'b0;
        we = 1'b0; acc_a = r_pc; wdata = '0; acc_go = 1'b0;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // take a new item only when the result slot is free by next edge
                if (i_q_valid && (!r_ovalid || i_ready)) begin
                    o_q_ready = 1'b1;
                    n_res = '{ST_OK, PK_NONE, 32'd0};
                    if (!i_q_item.op) begin
                        acc_a = {21'd0, i_q_item.load_address};
                        we    = (32'(i_q_item.load_address) < 32'(MEM_DEPTH));
                        wdata = i_q_item.load_value;
                        n_ovalid = 1'b1;
                    end else if (r_stop) begin
                        n_res.status = ST_IGNORED;
                        n_ovalid = 1'b1;
                    end else begin
                        if (i_q_item.timer_irq && !r_kern) begin
                            n_ssp = r_sp; n_spc = r_pc; n_sp = SP_KERNEL;
                            n_pc = VEC_TIMER; n_kern = 1'b1;
                        end
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                acc_a = r_pc;
                if (addr_ok(r_pc, r_kern)) n_state = S_FETCH_W;
                else n_state = S_DONE;
                n_res.status = addr_ok(r_pc, r_kern) ? ST_OK : ST_VIOL;
            end
            S_FETCH_W: begin
                n_opc = rdata;
                n_pc  = r_pc + 32'd1;
                if (rdata == OPC_SYSCALL && !r_kern) begin
                    n_ssp = r_sp; n_spc = r_pc + 32'd1; n_sp = SP_KERNEL;
                    n_pc = VEC_SYSCALL; n_kern = 1'b1;
                    n_state = S_DONE;
                end else if (has_operand(rdata)) begin
                    n_state = S_ARG;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_ARG: begin
                acc_a = r_pc;
                if (addr_ok(r_pc, r_kern)) n_state = S_ARG_W;
                else begin n_res.status = ST_VIOL; n_state = S_DONE; end
            end
            S_ARG_W: begin
                n_arg = rdata;
                n_pc  = r_pc + 32'd1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_ind = 1'b0;
                // memory-touching opcodes issue their access here
                priority case (r_opc)
                    OPC_LOAD_IMM:  n_ac = r_arg;
                    OPC_LOAD_DIR, OPC_LOAD_IND, OPC_LOAD_X, OPC_LOAD_Y, OPC_LOAD_SPX: begin
                        unique case (r_opc)
                            OPC_LOAD_X:   acc_a = r_arg + r_x;
                            OPC_LOAD_Y:   acc_a = r_arg + r_y;
                            OPC_LOAD_SPX: acc_a = r_sp + r_x;
                            default:      acc_a = r_arg;
                        endcase
                        acc_go = 1'b1;
                        n_ind = (r_opc == OPC_LOAD_IND);
                    end
                    OPC_STORE: begin
                        acc_a = r_arg; wdata = r_ac;
                        if (addr_ok(r_arg, r_kern)) we = 1'b1;
                        else n_res.status = ST_VIOL;
                    end
                    OPC_RAND: begin
                        n_lfsr = lf;
                        n_ac = {25'd0, rnd} + 32'd1;
                    end
                    OPC_PUT: begin
                        if (r_arg == 32'd1) n_res = '{ST_OK, PK_INT, r_ac};
                        else if (r_arg == 32'd2) n_res = '{ST_OK, PK_CHAR, r_ac};
                    end
                    OPC_ADD_X:      n_ac = r_ac + r_x;
                    OPC_ADD_Y:      n_ac = r_ac + r_y;
                    OPC_SUB_X:      n_ac = r_ac - r_x;
                    OPC_SUB_Y:      n_ac = r_ac - r_y;
                    OPC_CP_TO_X:    n_x = r_ac;
                    OPC_CP_FROM_X:  n_ac = r_x;
                    OPC_CP_TO_Y:    n_y = r_ac;
                    OPC_CP_FROM_Y:  n_ac = r_y;
                    OPC_CP_TO_SP:   n_sp = r_ac;
                    OPC_CP_FROM_SP: n_ac = r_sp;
                    OPC_JUMP:       n_pc = r_arg;
                    OPC_JUMP_EQ:    if (r_ac == 32'd0) n_pc = r_arg;
                    OPC_JUMP_NE:    if (r_ac != 32'd0) n_pc = r_arg;
                    OPC_CALL: begin
                        n_sp = r_sp - 32'd1;
                        acc_a = r_sp - 32'd1; wdata = r_pc;
                        if (addr_ok(r_sp - 32'd1, r_kern)) begin
                            we = 1'b1; n_pc = r_arg;
                        end else n_res.status = ST_VIOL;
                    end
                    OPC_PUSH: begin
                        n_sp = r_sp - 32'd1;
                        acc_a = r_sp - 32'd1; wdata = r_ac;
                        if (addr_ok(r_sp - 32'd1, r_kern)) we = 1'b1;
                        else n_res.status = ST_VIOL;
                    end
                    OPC_RET, OPC_POP: begin
                        acc_a = r_sp;
                        if (addr_ok(r_sp, r_kern)) n_state = S_POP_CLR;
                        else n_res.status = ST_VIOL;
                    end
                    OPC_INC_X: n_x = r_x + 32'd1;
                    OPC_DEC_X: n_x = r_x - 32'd1;
                    OPC_IRET: if (r_kern) begin
                        n_sp = r_ssp; n_pc = r_spc; n_kern = 1'b0;
                    end
                    OPC_END: n_res.status = ST_HALT;
                    default: ;
                endcase
                if (acc_go) begin
                    if (addr_ok(acc_a, r_kern)) n_state = S_MEM_W;
                    else n_res.status = ST_VIOL;
                end
            end
            S_MEM_W: begin
                if (r_ind) begin
                    n_arg = rdata;
                    n_ind = 1'b0;
                    acc_a = rdata;
                    if (addr_ok(rdata, r_kern)) n_state = S_IND_W;
                    else begin n_res.status = ST_VIOL; n_state = S_DONE; end
                end else begin
                    n_ac = rdata;
                    n_state = S_DONE;
                end
            end
            S_IND_W: begin
                n_ac = rdata;
                n_state = S_DONE;
            end
            S_POP_CLR: begin
                // clear the popped slot, then release SP
                acc_a = r_sp; we = 1'b1; wdata = '0;
                n_sp = r_sp + 32'd1;
                if (r_opc == OPC_RET) n_pc = rdata;
                else n_ac = rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    if (r_res.status == ST_VIOL) begin
                        n_res.print_kind = PK_NONE; n_res.print_value = '0;
                        n_stop = 1'b1;
                    end else if (r_res.status == ST_HALT) n_stop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: src/accumulator_cpu_core.sv
// Top level of the accumulator CPU core.
// Usage:
//   Input channel (i_valid/o_ready) carries items: op 0 writes load_value
//   into word memory at load_address, op 1 runs one whole instruction,
//   taking a timer interrupt first when i_timer_irq is set in user mode.
//   Output channel (o_valid/i_ready) returns exactly one result per item:
//   status, print kind and printed accumulator value.
//   A two-entry queue decouples input acceptance from the execution
//   sequencer, so items are taken while a result waits to be drained.
//   Steps are paced by the single-port word memory: fetch, operand,
//   data or indirect read, and pop read then slot clear each cost a
//   registered access of that one port.
//   Reset (i_rst_n low, synchronous) clears the registers to their
//   power-on values (SP 1000, LFSR 0xACE1, user mode); memory contents are
//   undefined until written.
//   When the receiver stalls, the result is held in the output register
//   and the sequencer waits; the queue keeps accepting up to two items.
//   After an end instruction or memory violation every step answers
//   status 3 until reset; load items still write memory.
module accumulator_cpu_core
    import acc_pkg::*;
#(
    parameter int MEM_DEPTH  = 2048,
    parameter int USER_LIMIT = 999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [10:0] i_load_address,
    input  logic [31:0] i_load_value,
    input  logic        i_timer_irq,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [1:0]  o_print_kind,
    output logic [31:0] o_print_value
);
    t_item   in_item, q_item;
    logic    q_valid, q_ready;
    t_result res;

    assign in_item = '{i_op, i_load_address, i_load_value, i_timer_irq};

    // Accept items and queue them.
    acc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (in_item),
        .o_q_valid(q_valid),
        .i_q_ready(q_ready),
        .o_q_item (q_item)
    );

    // Execute queued items.
    acc_back #(.MEM_DEPTH(MEM_DEPTH), .USER_LIMIT(USER_LIMIT)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .o_q_ready(q_ready),
        .i_q_item (q_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_res    (res)
    );

    assign o_status      = res.status;
    assign o_print_kind  = res.print_kind;
    assign o_print_value = res.print_value;
endmodule
